// File: rtl/core/memap_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package memap_pkg;

  localparam int MapRegs      = 8;
  localparam int NumMappingsD = 8;
  localparam int IdxW         = 3;
  localparam int CcDepth      = 2048;
  localparam int CcAddrW      = 11;
  localparam int PaddrW       = 6;

  localparam logic [1:0] RtNoteOn  = 2'd0;
  localparam logic [1:0] RtNoteOff = 2'd1;
  localparam logic [1:0] RtCc      = 2'd2;
  localparam logic [1:0] RtTick    = 2'd3;

  localparam logic [1:0] ActPulse  = 2'd0;
  localparam logic [1:0] ActFollow = 2'd1;
  localparam logic [1:0] ActPwm    = 2'd2;

  localparam logic [1:0] PmVel   = 2'd0;
  localparam logic [1:0] PmCc    = 2'd1;
  localparam logic [1:0] PmFixed = 2'd2;

  localparam logic [1:0] SusOff = 2'd1;
  localparam logic [1:0] SusOn  = 2'd2;

  localparam logic [6:0] SustainCc = 7'd64;
  localparam logic [6:0] HalfVal   = 7'd64;

  typedef struct packed {
    logic [1:0]  sus;
    logic [6:0]  vmax;
    logic [6:0]  vmin;
    logic [6:0]  pwmval;
    logic [15:0] dur;
    logic [1:0]  pwmmode;
    logic [1:0]  act;
    logic [4:0]  pin;
    logic [6:0]  num;
    logic [4:0]  ch;
    logic        ty;
    logic        en;
  } map_t;

  typedef struct packed {
    logic [4:0] pin;
    logic       kind;
    logic [7:0] level;
  } res_t;

  typedef struct packed {
    logic               clr;
    logic [CcAddrW-1:0] clr_addr;
    logic               load;
    logic               look;
    logic               eval;
    logic [IdxW-1:0]    idx;
    logic               flush;
  } cmd_t;

  typedef struct packed {
    logic stall;
    logic pend_valid;
    logic out_free;
  } sts_t;

  // x*255/127 truncated equals 2x, plus one at full scale
  function automatic logic [7:0] scale(input logic [6:0] x);
    scale = {x, 1'b0} + {7'd0, (x == 7'd127)};
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/memap_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface memap_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [3:0] channel;
  logic [6:0] number;
  logic [6:0] value;
  modport source(output valid, req_type, channel, number, value, input ready);
  modport sink(input valid, req_type, channel, number, value, output ready);
endinterface

interface memap_cmd_if;
  logic       valid;
  logic       ready;
  logic [4:0] pin;
  logic       drive_kind;
  logic [7:0] level;
  logic       last;
  modport source(output valid, pin, drive_kind, level, last, input ready);
  modport sink(input valid, pin, drive_kind, level, last, output ready);
endinterface
`default_nettype wire

// File: rtl/core/memap_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module memap_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// File: rtl/core/memap_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module memap_ctrl
  import memap_pkg::*;
#(
  parameter int NUM_MAPPINGS = NumMappingsD
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic req_valid_i,
  output logic      req_ready_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);
  typedef enum logic [2:0] {Clear, Idle, Look, Scan, Flush} state_e;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_MAPPINGS - 1);

  state_e             state_q, state_d;
  logic [IdxW-1:0]    idx_q, idx_d;
  logic [CcAddrW-1:0] clr_q, clr_d;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    clr_d   = clr_q;
    cmd_o   = '0;
    cmd_o.clr_addr = clr_q;
    cmd_o.idx      = idx_q;
    req_ready_o    = 1'b0;
    case (state_q)
      Clear: begin
        cmd_o.clr = 1'b1;
        clr_d = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = Idle;
        end
      end
      Idle: begin
        req_ready_o = 1'b1;
        cmd_o.load  = req_valid_i;
        if (req_valid_i) begin
          state_d = Look;
        end
      end
      Look: begin
        cmd_o.look = 1'b1;
        idx_d   = '0;
        state_d = Scan;
      end
      Scan: begin
        cmd_o.eval = 1'b1;
        if (!sts_i.stall) begin
          idx_d = idx_q + 1'b1;
          if (idx_q == LastIdx) begin
            state_d = Flush;
          end
        end
      end
      Flush: begin
        cmd_o.flush = 1'b1;
        if (!sts_i.pend_valid || sts_i.out_free) begin
          state_d = Idle;
        end
      end
      default: state_d = Idle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Clear;
      idx_q   <= '0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      clr_q   <= clr_d;
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/memap_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module memap_dp
  import memap_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cmd_t              cmd_i,
  output sts_t                   sts_o,
  input  wire logic [1:0]        req_type_i,
  input  wire logic [3:0]        channel_i,
  input  wire logic [6:0]        number_i,
  input  wire logic [6:0]        value_i,
  input  wire logic              cfg_we_i,
  input  wire logic [IdxW-1:0]   cfg_idx_i,
  input  wire logic [61:0]       cfg_data_i,
  output logic      [61:0]       cfg_rdata_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output res_t                   out_res_o,
  output logic                   out_last_o
);
  logic [61:0] map_q [MapRegs];
  logic [15:0] sustain_q;
  logic [MapRegs-1:0] run_q;
  logic [15:0] el_q [MapRegs];
  logic [1:0]  rt_q;
  logic [3:0]  ch_q;
  logic [6:0]  num_q, val_q;
  logic        pend_valid_q;
  res_t        pend_q;
  logic        out_valid_q, out_last_q;
  res_t        out_q;
  logic [6:0]  cc_rdata;

  map_t        m;
  logic [15:0] el_inc;
  logic        hit, set_t, stop_t, held, mch_ok, win_ok, sus_ok, base_ok;
  res_t        res;
  logic        out_free, commit, push_pend, push_flush;

  memap_ram #(.Width(7), .Depth(CcDepth)) u_cc (
    .clk_i  (clk_i),
    .we_i   (cmd_i.clr || (cmd_i.look && rt_q == RtCc)),
    .waddr_i(cmd_i.clr ? cmd_i.clr_addr : {ch_q, num_q}),
    .wdata_i(cmd_i.clr ? 7'd0 : val_q),
    .raddr_i({ch_q, num_q}),
    .rdata_o(cc_rdata)
  );

  assign cfg_rdata_o = map_q[cfg_idx_i];

  always_comb begin
    m      = map_t'(map_q[cmd_i.idx]);
    el_inc = (el_q[cmd_i.idx] == 16'hFFFF) ? el_q[cmd_i.idx] : el_q[cmd_i.idx] + 16'd1;
    held   = sustain_q[ch_q];
    mch_ok = (m.ch == 5'd0) || (m.ch == ({1'b0, ch_q} + 5'd1));
    win_ok = (rt_q != RtNoteOn) || (val_q >= m.vmin && val_q <= m.vmax);
    sus_ok = !((m.sus == SusOff && held) || (m.sus == SusOn && !held));
    base_ok = m.en && (m.ty == (rt_q == RtCc)) && mch_ok && (m.num == num_q)
              && win_ok && sus_ok;
    hit    = 1'b0;
    set_t  = 1'b0;
    stop_t = 1'b0;
    res    = '{pin: m.pin, kind: 1'b0, level: 8'd0};
    if (rt_q == RtTick) begin
      if (run_q[cmd_i.idx] && el_inc >= m.dur) begin
        if (m.act == ActPulse) begin
          hit = 1'b1;
          stop_t = 1'b1;
        end else if (m.act == ActPwm && m.pwmmode == PmFixed) begin
          hit = 1'b1;
          stop_t = 1'b1;
          res.kind = 1'b1;
        end
      end
    end else if (base_ok) begin
      case (rt_q)
        RtNoteOn: begin
          if (m.act == ActPulse) begin
            hit = 1'b1;
            set_t = 1'b1;
            res.level = 8'd1;
          end else if (m.act == ActFollow) begin
            hit = 1'b1;
            res.level = 8'd1;
          end else if (m.act == ActPwm) begin
            res.kind = 1'b1;
            if (m.pwmmode == PmVel) begin
              hit = 1'b1;
              res.level = scale(val_q);
            end else if (m.pwmmode == PmCc) begin
              hit = 1'b1;
              res.level = scale(cc_rdata);
            end else if (m.pwmmode == PmFixed) begin
              hit = 1'b1;
              set_t = 1'b1;
              res.level = scale(m.pwmval);
            end
          end
        end
        RtNoteOff: begin
          if (m.act == ActFollow) begin
            hit = 1'b1;
          end else if (m.act == ActPwm && m.pwmmode == PmVel) begin
            hit = 1'b1;
            res.kind = 1'b1;
          end
        end
        default: begin
          if (m.act == ActPwm && m.pwmmode == PmCc) begin
            hit = 1'b1;
            res.kind = 1'b1;
            res.level = scale(val_q);
          end
        end
      endcase
    end
  end

  assign out_free   = !out_valid_q || out_ready_i;
  assign sts_o.stall      = hit && pend_valid_q && !out_free;
  assign sts_o.pend_valid = pend_valid_q;
  assign sts_o.out_free   = out_free;
  assign commit     = cmd_i.eval && !sts_o.stall;
  assign push_pend  = commit && hit && pend_valid_q;
  assign push_flush = cmd_i.flush && pend_valid_q && out_free;

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;
  assign out_last_o  = out_last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rt_q  <= req_type_i;
      ch_q  <= channel_i;
      num_q <= number_i;
      val_q <= value_i;
    end
    if (commit && hit) begin
      pend_q <= res;
    end
    if (push_pend || push_flush) begin
      out_q      <= pend_q;
      out_last_q <= push_flush;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MapRegs; i++) begin
        map_q[i] <= '0;
        el_q[i]  <= '0;
      end
      sustain_q    <= '0;
      run_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        map_q[cfg_idx_i] <= cfg_data_i;
      end
      if (cmd_i.look && rt_q == RtCc && num_q == SustainCc) begin
        sustain_q[ch_q] <= (val_q >= HalfVal);
      end
      if (commit) begin
        if (rt_q == RtTick && run_q[cmd_i.idx]) begin
          el_q[cmd_i.idx] <= el_inc;
        end
        if (set_t) begin
          run_q[cmd_i.idx] <= 1'b1;
          el_q[cmd_i.idx]  <= '0;
        end
        if (stop_t) begin
          run_q[cmd_i.idx] <= 1'b0;
        end
        if (hit) begin
          pend_valid_q <= 1'b1;
        end
      end
      if (push_flush) begin
        pend_valid_q <= 1'b0;
      end
      if (push_pend || push_flush) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/midi_event_to_output_mapper_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Payload
// req       in   req_type, channel, number, value
// cmd       out  pin, drive_kind, level, last
// apb       in   mapping words 0..7 at paddr 8*i, 64-bit data
//
// After reset all 2048 CC store entries are zeroed; no request is taken then.
// A request goes through capture, store update, a scan of one mapping per cycle through
// the shared match unit unless the output stalls, then a flush of the held command.
// Commands pass through a one-deep output register; a stalled output holds the
// mapping scan until that register drains.
module midi_event_to_output_mapper_top
  import memap_pkg::*;
#(
  parameter int NUM_MAPPINGS = NumMappingsD
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  memap_req_if.sink              req,
  memap_cmd_if.source            cmd,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [PaddrW-1:0] paddr,
  input  wire logic [63:0]       pwdata,
  output logic      [63:0]       prdata,
  output logic                   pready
);
  cmd_t       dp_cmd;
  sts_t       dp_sts;
  res_t       res;
  logic [61:0] rdata;

  assign pready = 1'b1;
  assign prdata = {2'b00, rdata};

  memap_ctrl #(.NUM_MAPPINGS(NUM_MAPPINGS)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req.valid),
    .req_ready_o(req.ready),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  memap_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (dp_cmd),
    .sts_o      (dp_sts),
    .req_type_i (req.req_type),
    .channel_i  (req.channel),
    .number_i   (req.number),
    .value_i    (req.value),
    .cfg_we_i   (psel && penable && pwrite),
    .cfg_idx_i  (paddr[PaddrW-1:3]),
    .cfg_data_i (pwdata[61:0]),
    .cfg_rdata_o(rdata),
    .out_valid_o(cmd.valid),
    .out_ready_i(cmd.ready),
    .out_res_o  (res),
    .out_last_o (cmd.last)
  );

  assign cmd.pin        = res.pin;
  assign cmd.drive_kind = res.kind;
  assign cmd.level      = res.level;
endmodule
`default_nettype wire

// File: verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import memap_pkg::*;

  typedef struct {
    logic [4:0] pin;
    logic       kind;
    logic [7:0] level;
    logic       last;
  } drive_cmd_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PaddrW-1:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  memap_req_if req_bus ();
  memap_cmd_if cmd_bus ();

  midi_event_to_output_mapper_top DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .req(req_bus.sink), .cmd(cmd_bus.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  map_t       map_words [8];
  logic       sus_held [16];
  logic [6:0] cc_vals [2048];
  logic       tmr_run [8];
  logic [15:0] tmr_ms [8];

  drive_cmd_t pending_cmds[$];
  int errors = 0;
  int n_reqs = 0;
  int n_cmds = 0;
  bit hold_cmds = 1'b0;
  bit lean_idle = 1'b0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #4000000;
    $display("Timeout");
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [7:0] duty_of(input logic [6:0] x);
    int unsigned t;
    t = (int'(x) * 255) / 127;
    return t[7:0];
  endfunction

  function automatic void push_cmd(input logic [4:0] pin, input logic kind,
                                   input logic [7:0] level);
    drive_cmd_t c;
    c.pin = pin;
    c.kind = kind;
    c.level = level;
    c.last = 1'b0;
    pending_cmds.push_back(c);
  endfunction

  function automatic void predict_drives(input logic [1:0] rt, input logic [3:0] ch,
                                         input logic [6:0] num, input logic [6:0] val);
    int before_n;
    map_t m;
    logic held;
    drive_cmd_t c;
    before_n = pending_cmds.size();
    if (rt == RtTick) begin
      for (int i = 0; i < 8; i++) begin
        m = map_words[i];
        if (!tmr_run[i]) continue;
        if (tmr_ms[i] != 16'hffff) tmr_ms[i]++;
        if (tmr_ms[i] < m.dur) continue;
        if (m.act == ActPulse) begin
          push_cmd(m.pin, 1'b0, 8'd0);
          tmr_run[i] = 1'b0;
        end else if (m.act == ActPwm && m.pwmmode == PmFixed) begin
          push_cmd(m.pin, 1'b1, 8'd0);
          tmr_run[i] = 1'b0;
        end
      end
    end else begin
      if (rt == RtCc) begin
        if (num == SustainCc) sus_held[ch] = (val >= HalfVal);
        cc_vals[{ch, num}] = val;
      end
      held = sus_held[ch];
      for (int i = 0; i < 8; i++) begin
        m = map_words[i];
        if (!m.en || m.ty != (rt == RtCc)) continue;
        if (m.ch != 0 && m.ch != {1'b0, ch} + 5'd1) continue;
        if (m.num != num) continue;
        if (rt == RtNoteOn && (val < m.vmin || val > m.vmax)) continue;
        if (m.sus == SusOff && held) continue;
        if (m.sus == SusOn && !held) continue;
        if (rt == RtNoteOn) begin
          if (m.act == ActPulse) begin
            push_cmd(m.pin, 1'b0, 8'd1);
            tmr_run[i] = 1'b1;
            tmr_ms[i] = '0;
          end else if (m.act == ActFollow) begin
            push_cmd(m.pin, 1'b0, 8'd1);
          end else if (m.act == ActPwm) begin
            if (m.pwmmode == PmVel) push_cmd(m.pin, 1'b1, duty_of(val));
            else if (m.pwmmode == PmCc) push_cmd(m.pin, 1'b1, duty_of(cc_vals[{ch, m.num}]));
            else if (m.pwmmode == PmFixed) begin
              push_cmd(m.pin, 1'b1, duty_of(m.pwmval));
              tmr_run[i] = 1'b1;
              tmr_ms[i] = '0;
            end
          end
        end else if (rt == RtNoteOff) begin
          if (m.act == ActFollow) push_cmd(m.pin, 1'b0, 8'd0);
          else if (m.act == ActPwm && m.pwmmode == PmVel) push_cmd(m.pin, 1'b1, 8'd0);
        end else if (m.act == ActPwm && m.pwmmode == PmCc) begin
          push_cmd(m.pin, 1'b1, duty_of(val));
        end
      end
    end
    if (pending_cmds.size() > before_n) begin
      c = pending_cmds[$];
      c.last = 1'b1;
      pending_cmds[pending_cmds.size() - 1] = c;
    end
  endfunction

  task automatic report_mismatch(input string what);
    errors++;
    $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  function automatic int pick_gap();
    if (lean_idle) return 0;
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  task automatic send_request(input logic [1:0] rt, input logic [3:0] ch,
                              input logic [6:0] num, input logic [6:0] val);
    int gap;
    gap = pick_gap();
    repeat (gap + 1) @(negedge clk_i);
    req_bus.valid <= 1'b1;
    req_bus.req_type <= rt;
    req_bus.channel <= ch;
    req_bus.number <= num;
    req_bus.value <= val;
    do @(posedge clk_i); while (!req_bus.ready);
    predict_drives(rt, ch, num, val);
    n_reqs++;
    @(negedge clk_i);
    req_bus.valid <= 1'b0;
  endtask

  task automatic write_map(input int idx, input map_t w);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= PaddrW'(idx * 8);
    pwdata <= {2'b00, w};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    map_words[idx] = w;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_cmds.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (hold_cmds) cmd_bus.ready <= 1'b0;
    else if (lean_idle) cmd_bus.ready <= 1'b1;
    else cmd_bus.ready <= ($urandom_range(0, 9) == 0) ? 1'b0 :
                          ($urandom_range(0, 4) != 0);
  end

  always @(posedge clk_i) begin
    drive_cmd_t e;
    if (rst_ni && cmd_bus.valid && cmd_bus.ready) begin
      n_cmds++;
      if (pending_cmds.size() == 0) begin
        report_mismatch($sformatf("unexpected command pin %0d", cmd_bus.pin));
      end else begin
        e = pending_cmds.pop_front();
        if (cmd_bus.pin !== e.pin)
          report_mismatch($sformatf("pin %0d exp %0d", cmd_bus.pin, e.pin));
        if (cmd_bus.drive_kind !== e.kind)
          report_mismatch($sformatf("kind %0b exp %0b", cmd_bus.drive_kind, e.kind));
        if (cmd_bus.level !== e.level)
          report_mismatch($sformatf("level %0d exp %0d", cmd_bus.level, e.level));
        if (cmd_bus.last !== e.last)
          report_mismatch($sformatf("last %0b exp %0b", cmd_bus.last, e.last));
      end
    end
  end

  function automatic map_t rand_map();
    map_t m;
    m = map_t'(62'({$urandom, $urandom}));
    m.en = ($urandom_range(0, 5) != 0);
    m.ch = ($urandom_range(0, 2) == 0) ? 5'd0 :
           ($urandom_range(0, 7) == 0) ? 5'($urandom_range(17, 31)) :
           5'($urandom_range(1, 4));
    m.num = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(60, 64));
    m.dur = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
    if ($urandom_range(0, 1)) begin
      m.vmin = 7'($urandom_range(0, 40));
      m.vmax = 7'($urandom_range(80, 127));
    end
    if ($urandom_range(0, 1)) m.sus = 2'd0;
    return m;
  endfunction

  task automatic rand_request();
    logic [1:0] rt;
    logic [6:0] num;
    rt = 2'($urandom);
    num = ($urandom_range(0, 4) == 0) ? 7'($urandom) : 7'($urandom_range(60, 64));
    send_request(rt, 4'($urandom_range(0, 4) == 0 ? $urandom : $urandom_range(0, 3)),
                 num, 7'($urandom));
  endtask

  task automatic test_directed();
    map_t m;
    m = '0;
    m.en = 1'b1; m.ch = 5'd0; m.num = 7'd60; m.pin = 5'd31; m.act = ActPulse;
    m.dur = 16'd2; m.vmin = 7'd0; m.vmax = 7'd127;
    write_map(0, m);
    m.ch = 5'd16; m.pin = 5'd1; m.act = ActFollow; m.vmin = 7'd10; m.vmax = 7'd100;
    write_map(1, m);
    m.ch = 5'd0; m.pin = 5'd2; m.act = ActPwm; m.pwmmode = PmVel; m.vmin = 7'd0;
    m.vmax = 7'd127;
    write_map(2, m);
    m.pin = 5'd3; m.pwmmode = PmCc;
    write_map(3, m);
    m.pin = 5'd4; m.pwmmode = PmFixed; m.pwmval = 7'd127; m.dur = 16'd1;
    write_map(4, m);
    m.ty = 1'b1; m.pin = 5'd5; m.pwmmode = PmCc; m.sus = SusOn; m.num = 7'd60;
    write_map(5, m);
    m.ty = 1'b0; m.pin = 5'd6; m.act = 2'd3; m.sus = 2'd3;
    write_map(6, m);
    m.pin = 5'd7; m.act = ActFollow; m.sus = SusOff; m.ch = 5'd20;
    write_map(7, m);
    send_request(RtNoteOn, 4'd15, 7'd60, 7'd127);
    send_request(RtNoteOn, 4'd15, 7'd60, 7'd0);
    send_request(RtNoteOn, 4'd0, 7'd60, 7'd5);
    send_request(RtNoteOff, 4'd15, 7'd60, 7'd77);
    send_request(RtTick, 4'd15, 7'd127, 7'd127);
    send_request(RtTick, 4'd0, 7'd0, 7'd0);
    send_request(RtCc, 4'd15, 7'd60, 7'd127);
    send_request(RtCc, 4'd15, SustainCc, 7'd64);
    send_request(RtCc, 4'd15, 7'd60, 7'd1);
    send_request(RtNoteOn, 4'd15, 7'd60, 7'd100);
    send_request(RtCc, 4'd15, SustainCc, 7'd63);
    send_request(RtNoteOn, 4'd15, 7'd60, 7'd101);
    send_request(RtNoteOn, 4'd3, 7'd127, 7'd127);
    send_request(RtTick, 4'd0, 7'd0, 7'd0);
    send_request(RtTick, 4'd0, 7'd0, 7'd0);
    wait_idle();
    m = '1;
    m.sus = 2'd0; m.ch = 5'd0; m.num = 7'd64; m.dur = 16'hffff;
    write_map(0, m);
    send_request(RtCc, 4'd3, 7'd64, 7'd127);
    send_request(RtTick, 4'd0, 7'd0, 7'd0);
  endtask

  task automatic test_backpressure();
    map_t m;
    wait_idle();
    m = '0;
    m.en = 1'b1; m.act = ActFollow; m.num = 7'd62; m.vmax = 7'd127;
    for (int i = 0; i < 8; i++) begin
      m.pin = 5'(i + 8);
      write_map(i, m);
    end
    hold_cmds = 1'b1;
    fork
      begin
        repeat (200) @(posedge clk_i);
        hold_cmds = 1'b0;
      end
      for (int k = 0; k < 6; k++) send_request(RtNoteOn, 4'($urandom), 7'd62, 7'($urandom));
    join
  endtask

  task automatic test_random(input int rounds, input int per_round);
    for (int r = 0; r < rounds; r++) begin
      wait_idle();
      for (int i = 0; i < 8; i++) write_map(i, rand_map());
      lean_idle = (r == 1);
      for (int k = 0; k < per_round; k++) rand_request();
      lean_idle = 1'b0;
    end
  endtask

  initial begin
    req_bus.valid = 1'b0;
    req_bus.req_type = '0;
    req_bus.channel = '0;
    req_bus.number = '0;
    req_bus.value = '0;
    cmd_bus.ready = 1'b0;
    for (int i = 0; i < 8; i++) begin
      map_words[i] = '0;
      tmr_run[i] = 1'b0;
      tmr_ms[i] = '0;
    end
    for (int i = 0; i < 16; i++) sus_held[i] = 1'b0;
    for (int i = 0; i < 2048; i++) cc_vals[i] = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_backpressure();
    test_random(6, 23);
    wait_idle();
    $display("Covered %0d requests and %0d drive commands, all request kinds,",
             n_reqs, n_cmds);
    $display("timers, sustain gating, CC levels and a long output stall.");
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/memap_pkg.sv
rtl/core/memap_if.sv
rtl/core/memap_ram.sv
rtl/core/memap_ctrl.sv
rtl/core/memap_dp.sv
rtl/core/midi_event_to_output_mapper_top.sv
verif/tb_top.sv
